/* src/ils_pkg.sv */
// Shared types and constants for the indexed list store.
`timescale 1ns / 1ps

package ils_pkg;

	// Request commands.
	typedef enum logic [3:0] {
		CMD_PUSH_FRONT = 4'd0,
		CMD_PUSH_BACK  = 4'd1,
		CMD_POP_FRONT  = 4'd2,
		CMD_POP_BACK   = 4'd3,
		CMD_INSERT     = 4'd4,
		CMD_REMOVE     = 4'd5,
		CMD_READ_FRONT = 4'd6,
		CMD_READ_BACK  = 4'd7,
		CMD_FIND       = 4'd8
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Entry update applied by every cell in the same cycle.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_OPEN,
		CELL_CLOSE
	} cell_op_t;

	// Handling of the match flag and tap register in each cell.
	typedef enum logic [1:0] {
		SCAN_HOLD,
		SCAN_LOAD,
		SCAN_SHIFT
	} scan_op_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_SCAN
	} fsm_t;

	// Control broadcast from the sequencer to the cell row.
	typedef struct packed {
		cell_op_t op;
		scan_op_t scan;
		logic     find;
	} cell_ctl_t;

	// Cells examined per sweep cycle; the sweep moves flags this far each cycle.
	localparam int LANES  = 8;
	localparam int LANE_W = 3;

endpackage

/* src/ils_cell.sv */
// One cell of the list row: holds an entry, shifts it, and compares it.
`timescale 1ns / 1ps

module ils_cell #(
	parameter int DATA_WIDTH = 32,
	parameter int CNT_W      = 7,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  ils_pkg::cell_ctl_t    ctl,
	input  logic [CNT_W-1:0]      k,
	input  logic [CNT_W-1:0]      count,
	input  logic [DATA_WIDTH-1:0] new_data,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	input  logic                  far_match,
	input  logic [DATA_WIDTH-1:0] far_tap,
	output logic [DATA_WIDTH-1:0] entry,
	output logic                  match,
	output logic [DATA_WIDTH-1:0] tap
);
	import ils_pkg::*;

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic [DATA_WIDTH-1:0] entry_q;
	logic [DATA_WIDTH-1:0] tap_q;
	logic                  match_q;
	logic                  hit_d;

	// Find: value match inside the occupied range; read: this cell is the target.
	assign hit_d = ctl.find ? ((entry_q == new_data) && (IDX_C < count)) : (IDX_C == k);

	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_OPEN: begin
				if (IDX_C > k) begin
					entry_q <= left;
				end else if (IDX_C == k) begin
					entry_q <= new_data;
				end
			end
			CELL_CLOSE: begin
				if (IDX_C >= k) begin
					entry_q <= right;
				end
			end
			default: ;
		endcase

		case (ctl.scan)
			SCAN_LOAD: begin
				match_q <= hit_d;
				tap_q   <= entry_q;
			end
			SCAN_SHIFT: begin
				match_q <= far_match;
				tap_q   <= far_tap;
			end
			default: ;
		endcase
	end

	assign entry = entry_q;
	assign match = match_q;
	assign tap   = tap_q;

endmodule

/* src/indexed_list_store.sv */
// Top level of the indexed list store: request sequencer and cell row.
`timescale 1ns / 1ps

// Bounded ordered list of up to CAPACITY values, position zero at the front.
// A request is taken when start is high and busy is low. Push, pop, insert
// and remove requests (and any request refused for an empty or full list)
// finish without a sweep: the result strobe done rises in the cycle after the
// request and busy stays low, so a new request may follow every cycle.
// Read front, read back and find load a match flag into every cell and then
// sweep the flags toward the front, eight cells per cycle; busy is high
// for the sweep, which ends once the target or first match reaches the
// front lanes, or, for a find that misses, once the sweep passes the
// occupied range. The result strobe follows the last sweep cycle. Each result
// is shown for exactly one cycle with done high; there is no way to hold it
// off, so the receiver must take it then. Every result carries the count
// after the request.
module indexed_list_store #(
	parameter int CAPACITY   = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  cmd,
	input  logic [5:0]  position,
	input  logic [31:0] value,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] read_value,
	output logic [6:0]  found_position,
	output logic [6:0]  count
);
	import ils_pkg::*;

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int PW     = (CNT_W > 6) ? CNT_W : 6;
	localparam int OW     = (CNT_W > 7) ? CNT_W : 7;
	localparam int EXT    = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
	localparam int SCAN_W = $clog2(CAPACITY + LANES + 1);

	// Sequencer state.
	fsm_t              state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [SCAN_W-1:0] base_q, base_d;
	logic              find_q, find_d;

	// Result registers.
	logic                  done_q, done_d;
	status_t               status_q, status_d;
	logic [DATA_WIDTH-1:0] read_q, read_d;
	logic [CNT_W-1:0]      found_q, found_d;

	// Cell row control.
	cell_ctl_t             ctl;
	logic [CNT_W-1:0]      k_d;
	logic [DATA_WIDTH-1:0] key;
	logic [EXT-1:0]        value_ext;

	// Cell row wiring.
	logic [DATA_WIDTH-1:0] entry_w [CAPACITY];
	logic [DATA_WIDTH-1:0] tap_w   [CAPACITY];
	logic                  match_w [CAPACITY];
	logic [DATA_WIDTH-1:0] left_w  [CAPACITY];
	logic [DATA_WIDTH-1:0] right_w [CAPACITY];
	logic                  far_m_w [CAPACITY];
	logic [DATA_WIDTH-1:0] far_t_w [CAPACITY];

	// Front lanes seen by the sweep.
	logic                  lane_match [LANES];
	logic [DATA_WIDTH-1:0] lane_tap   [LANES];
	logic                  lane_any;
	logic [LANE_W-1:0]     hit_lane;

	cmd_t             cmd_c;
	logic [PW-1:0]    pos_w;
	logic [PW-1:0]    cnt_w;
	logic             full;
	logic             empty;
	logic [SCAN_W-1:0] scan_next;
	logic [SCAN_W-1:0] found_sum;

	assign cmd_c     = cmd_t'(cmd);
	assign pos_w     = PW'(position);
	assign cnt_w     = PW'(count_q);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);
	assign value_ext = EXT'(value);
	assign key       = value_ext[DATA_WIDTH-1:0];
	assign scan_next = base_q + SCAN_W'(LANES);
	assign found_sum = base_q + SCAN_W'(hit_lane);

	// Build the row: each cell sees its neighbors and the cell one sweep
	// stride behind it; the row ends read as zero.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		if (i == 0) begin : g_head
			assign left_w[i] = '0;
		end else begin : g_body
			assign left_w[i] = entry_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_w[i] = '0;
		end else begin : g_inner
			assign right_w[i] = entry_w[i+1];
		end
		if (i + LANES < CAPACITY) begin : g_far
			assign far_m_w[i] = match_w[i+LANES];
			assign far_t_w[i] = tap_w[i+LANES];
		end else begin : g_far_end
			assign far_m_w[i] = 1'b0;
			assign far_t_w[i] = '0;
		end

		ils_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.CNT_W     (CNT_W),
			.IDX       (i)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.k        (k_d),
			.count    (count_q),
			.new_data (key),
			.left     (left_w[i]),
			.right    (right_w[i]),
			.far_match(far_m_w[i]),
			.far_tap  (far_t_w[i]),
			.entry    (entry_w[i]),
			.match    (match_w[i]),
			.tap      (tap_w[i])
		);
	end

	// Pad the front lanes when the row is shorter than one stride.
	for (genvar l = 0; l < LANES; l++) begin : g_lane
		if (l < CAPACITY) begin : g_used
			assign lane_match[l] = match_w[l];
			assign lane_tap[l]   = tap_w[l];
		end else begin : g_pad
			assign lane_match[l] = 1'b0;
			assign lane_tap[l]   = '0;
		end
	end

	// Lowest flagged lane wins.
	always_comb begin
		lane_any = 1'b0;
		hit_lane = '0;
		for (int l = LANES - 1; l >= 0; l--) begin
			if (lane_match[l]) begin
				lane_any = 1'b1;
				hit_lane = LANE_W'(l);
			end
		end
	end

	// Next state, cell control and result.
	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		base_d   = base_q;
		find_d   = find_q;
		ctl      = '{op: CELL_HOLD, scan: SCAN_HOLD, find: 1'b0};
		k_d      = '0;
		done_d   = 1'b0;
		status_d = ST_OK;
		read_d   = '0;
		found_d  = '0;

		case (state_q)
			FSM_IDLE: begin
				if (start) begin
					case (cmd_c)
						CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT: begin
							done_d = 1'b1;
							if (full) begin
								status_d = ST_FULL;
							end else begin
								// Open a gap at the target; past the end means append.
								ctl.op  = CELL_OPEN;
								count_d = count_q + 1'b1;
								if (cmd_c == CMD_PUSH_FRONT) begin
									k_d = '0;
								end else if (cmd_c == CMD_PUSH_BACK || pos_w > cnt_w) begin
									k_d = count_q;
								end else begin
									k_d = pos_w[CNT_W-1:0];
								end
							end
						end
						CMD_POP_FRONT, CMD_POP_BACK: begin
							done_d = 1'b1;
							if (empty) begin
								status_d = ST_RANGE;
							end else begin
								// Popping the back only drops the count.
								count_d = count_q - 1'b1;
								if (cmd_c == CMD_POP_FRONT) begin
									ctl.op = CELL_CLOSE;
									k_d    = '0;
								end
							end
						end
						CMD_REMOVE: begin
							done_d = 1'b1;
							if (pos_w >= cnt_w) begin
								status_d = ST_RANGE;
							end else begin
								ctl.op  = CELL_CLOSE;
								k_d     = pos_w[CNT_W-1:0];
								count_d = count_q - 1'b1;
							end
						end
						CMD_READ_FRONT, CMD_READ_BACK: begin
							if (empty) begin
								done_d   = 1'b1;
								status_d = ST_RANGE;
							end else begin
								// Flag the target cell, then sweep it to the front.
								ctl.scan = SCAN_LOAD;
								k_d      = (cmd_c == CMD_READ_FRONT) ? '0 : count_q - 1'b1;
								base_d   = '0;
								find_d   = 1'b0;
								state_d  = FSM_SCAN;
							end
						end
						CMD_FIND: begin
							ctl.scan = SCAN_LOAD;
							ctl.find = 1'b1;
							base_d   = '0;
							find_d   = 1'b1;
							state_d  = FSM_SCAN;
						end
						default: begin
							done_d   = 1'b1;
							status_d = ST_RANGE;
						end
					endcase
				end
			end
			FSM_SCAN: begin
				// Advance the flags one stride toward the front each cycle.
				ctl.scan = SCAN_SHIFT;
				base_d   = scan_next;
				if (lane_any) begin
					done_d  = 1'b1;
					state_d = FSM_IDLE;
					if (find_q) begin
						found_d = found_sum[CNT_W-1:0];
					end else begin
						read_d = lane_tap[hit_lane];
					end
				end else if (scan_next >= SCAN_W'(count_q)) begin
					// Swept past the occupied range without a hit.
					done_d  = 1'b1;
					state_d = FSM_IDLE;
					if (find_q) begin
						found_d = count_q;
					end
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
			count_q <= '0;
			base_q  <= '0;
			find_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			base_q  <= base_d;
			find_q  <= find_d;
			done_q  <= done_d;
		end
	end

	// Result payload: only meaningful while done is high.
	always_ff @(posedge clk) begin
		status_q <= status_d;
		read_q   <= read_d;
		found_q  <= found_d;
	end

	logic [EXT-1:0] read_ext;
	logic [OW-1:0]  found_ext;
	logic [OW-1:0]  count_ext;

	assign read_ext  = EXT'(read_q);
	assign found_ext = OW'(found_q);
	assign count_ext = OW'(count_q);

	assign busy           = (state_q != FSM_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign read_value     = read_ext[31:0];
	assign found_position = found_ext[6:0];
	assign count          = count_ext[6:0];

endmodule

/* src/ils_checker.sv */
// Port-level checks for the indexed list store, bound to its top level.
`timescale 1ns / 1ps

module ils_checker #(
	parameter int CAPACITY = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [31:0] read_value,
	input logic [6:0]  found_position,
	input logic [6:0]  count
);
	import ils_pkg::*;

	// A result only follows a taken request or a running sweep.
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy) || $past(busy)))
		else $error("result without a request");

	// The count moves only at the edge that takes a request.
	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start && !busy) |-> $stable(count))
		else $error("count changed without a request");

	// A full refusal only happens at capacity.
	a_full_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (count == 7'(CAPACITY)))
		else $error("full status below capacity");

	// Refused requests return no data.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (read_value == '0 && found_position == '0))
		else $error("error result carries data");

	// The count never passes capacity.
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		(CAPACITY > 127) || (count <= 7'(CAPACITY)))
		else $error("count above capacity");

endmodule

bind indexed_list_store ils_checker #(
	.CAPACITY(CAPACITY)
) u_ils_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.read_value    (read_value),
	.found_position(found_position),
	.count         (count)
);
